### src/sfs_pkg.sv
// Shared constants, codes and types of the sprite frame sequencer.
package sfs_pkg;

	localparam int MAX_FRAMES     = 256;
	localparam int IMAGE_DIM_BITS = 12;

	localparam int DIM_W      = IMAGE_DIM_BITS;
	localparam int FRAME_W    = 8;
	localparam int FC_W       = FRAME_W + 1;
	localparam int CELL_W     = 12;
	localparam int DVS_W      = 7;
	localparam int DIV_W      = (DIM_W > CELL_W) ? DIM_W : CELL_W;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int TBL_AW     = $clog2(MAX_FRAMES);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PLAY_DIRECTION = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS      = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_OWN_FLIP_H     = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_OWN_FLIP_V     = CFG_IDX_W'(6);

	localparam logic [1:0] MODE_IMAGE = 2'd0;
	localparam logic [1:0] MODE_GRID  = 2'd1;
	localparam logic [1:0] MODE_SEQ   = 2'd2;

	localparam logic [1:0] DIR_FWD = 2'd0;
	localparam logic [1:0] DIR_BWD = 2'd1;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_DRAW  = 2'd1,
		ACT_SET   = 2'd2,
		ACT_WRITE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SETUP,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		action_t             action;
		logic [FRAME_W-1:0]  frame_number;
		logic [CELL_W-1:0]   cell_value;
		logic [DIM_W-1:0]    image_width;
		logic [DIM_W-1:0]    image_height;
		logic                actor_mirror_h;
		logic                actor_mirror_v;
	} item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] shown_frame;
		logic [DIM_W-1:0]   src_x;
		logic [DIM_W-1:0]   src_y;
		logic [DIM_W-1:0]   cell_width;
		logic [DIM_W-1:0]   cell_height;
		logic               flip_h;
		logic               flip_v;
		logic               finished;
	} result_t;

	typedef struct packed {
		logic capture;
		logic setup;
		logic div_step;
		logic mul;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_status_t;

endpackage

### src/sfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfs_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/sfs_datapath.sv
// Datapath: configuration, current frame, cell table, divider lanes and result register.
module sfs_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  sfs_pkg::item_t                  item,
	input  sfs_pkg::dp_cmd_t                cmd,
	output sfs_pkg::dp_status_t             status,
	output sfs_pkg::result_t                result
);

	localparam int PX_W = sfs_pkg::DVS_W + sfs_pkg::DIM_W;
	localparam int PY_W = sfs_pkg::DIV_W + sfs_pkg::DIM_W;
	localparam int LANE_W = sfs_pkg::DVS_W + sfs_pkg::DIV_W;
	localparam logic [sfs_pkg::FRAME_W-1:0] FRAME_MAX = '1;
	localparam logic [sfs_pkg::DIM_W-1:0] DIM_MAX = '1;

	function automatic logic [LANE_W-1:0] div_step(
		input logic [sfs_pkg::DVS_W-1:0] rem,
		input logic [sfs_pkg::DIV_W-1:0] num,
		input logic [sfs_pkg::DVS_W-1:0] dvs
	);
		logic [sfs_pkg::DVS_W:0] trial;
		logic [sfs_pkg::DVS_W:0] diff;
		trial = {rem, num[sfs_pkg::DIV_W-1]};
		diff  = trial - {1'b0, dvs};
		if (trial >= {1'b0, dvs}) begin
			return {diff[sfs_pkg::DVS_W-1:0], num[sfs_pkg::DIV_W-2:0], 1'b1};
		end
		return {trial[sfs_pkg::DVS_W-1:0], num[sfs_pkg::DIV_W-2:0], 1'b0};
	endfunction

	logic [1:0]                   mode_q;
	logic [1:0]                   dir_q;
	logic [sfs_pkg::FC_W-1:0]     frame_count_q;
	logic [sfs_pkg::DVS_W-1:0]    grid_cols_q;
	logic [sfs_pkg::DVS_W-1:0]    grid_rows_q;
	logic                         own_flip_h_q;
	logic                         own_flip_v_q;

	logic [sfs_pkg::FRAME_W-1:0]  cur_q;
	logic                         fin_q;
	logic [sfs_pkg::DIM_W-1:0]    iw_q;
	logic [sfs_pkg::DIM_W-1:0]    ih_q;
	logic                         flip_h_q;
	logic                         flip_v_q;

	logic [sfs_pkg::DIV_W-1:0]    num_w_q, num_h_q, num_c_q;
	logic [sfs_pkg::DVS_W-1:0]    rem_w_q, rem_h_q, rem_c_q;
	logic [sfs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [PX_W-1:0]              prod_x_q;
	logic [PY_W-1:0]              prod_y_q;
	sfs_pkg::result_t             res_q;

	logic [sfs_pkg::FC_W-1:0]     fc_m1;
	logic [sfs_pkg::FRAME_W-1:0]  last_frame;
	logic [sfs_pkg::FRAME_W-1:0]  next_frame;
	logic                         next_fin;
	logic                         tbl_we;
	logic [sfs_pkg::CELL_W-1:0]   tbl_rdata;
	logic                         rd_ok;
	logic [sfs_pkg::CELL_W-1:0]   cell_idx;
	logic [LANE_W-1:0]            step_w, step_h, step_c;
	logic                         grid_mode;
	logic                         grid_ok;
	logic [sfs_pkg::DIM_W-1:0]    sat_x, sat_y;
	sfs_pkg::result_t             res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= sfs_pkg::MODE_IMAGE;
			dir_q         <= sfs_pkg::DIR_FWD;
			frame_count_q <= '0;
			grid_cols_q   <= sfs_pkg::DVS_W'(1);
			grid_rows_q   <= sfs_pkg::DVS_W'(1);
			own_flip_h_q  <= 1'b0;
			own_flip_v_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfs_pkg::REG_ANIM_MODE:      mode_q        <= cfg_data[1:0];
				sfs_pkg::REG_PLAY_DIRECTION: dir_q         <= cfg_data[1:0];
				sfs_pkg::REG_FRAME_COUNT:    frame_count_q <= cfg_data[sfs_pkg::FC_W-1:0];
				sfs_pkg::REG_GRID_COLS:      grid_cols_q   <= cfg_data[sfs_pkg::DVS_W-1:0];
				sfs_pkg::REG_GRID_ROWS:      grid_rows_q   <= cfg_data[sfs_pkg::DVS_W-1:0];
				sfs_pkg::REG_OWN_FLIP_H:     own_flip_h_q  <= cfg_data[0];
				sfs_pkg::REG_OWN_FLIP_V:     own_flip_v_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign fc_m1 = frame_count_q - 1'b1;

	always_comb begin
		if (frame_count_q == '0) begin
			last_frame = '0;
		end else if (fc_m1 > {1'b0, FRAME_MAX}) begin
			last_frame = FRAME_MAX;
		end else begin
			last_frame = fc_m1[sfs_pkg::FRAME_W-1:0];
		end
	end

	always_comb begin
		next_frame = cur_q;
		next_fin   = 1'b0;
		unique case (item.action)
			sfs_pkg::ACT_TICK: begin
				if (dir_q == sfs_pkg::DIR_FWD) begin
					if (cur_q >= last_frame) begin
						next_frame = '0;
						next_fin   = 1'b1;
					end else begin
						next_frame = cur_q + 1'b1;
					end
				end else if (dir_q == sfs_pkg::DIR_BWD) begin
					if (cur_q == '0) begin
						next_frame = last_frame;
						next_fin   = 1'b1;
					end else begin
						next_frame = cur_q - 1'b1;
					end
				end
			end
			sfs_pkg::ACT_DRAW:  next_frame = item.frame_number;
			sfs_pkg::ACT_SET: begin
				next_frame = ({1'b0, item.frame_number} < frame_count_q) ?
					item.frame_number : '0;
			end
			sfs_pkg::ACT_WRITE: next_frame = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cmd.capture) begin
			cur_q <= next_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fin_q    <= next_fin;
			iw_q     <= item.image_width;
			ih_q     <= item.image_height;
			flip_h_q <= own_flip_h_q ^ item.actor_mirror_h;
			flip_v_q <= own_flip_v_q ^ item.actor_mirror_v;
		end
	end

	assign tbl_we = cmd.capture && (item.action == sfs_pkg::ACT_WRITE) &&
		(32'(item.frame_number) < 32'(sfs_pkg::MAX_FRAMES));

	sfs_ram #(
		.WIDTH (sfs_pkg::CELL_W),
		.DEPTH (sfs_pkg::MAX_FRAMES)
	) u_cell_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (sfs_pkg::TBL_AW'(item.frame_number)),
		.wdata (item.cell_value),
		.raddr (sfs_pkg::TBL_AW'(cur_q)),
		.rdata (tbl_rdata)
	);

	assign rd_ok    = 32'(cur_q) < 32'(sfs_pkg::MAX_FRAMES);
	assign cell_idx = (mode_q == sfs_pkg::MODE_SEQ) ? (rd_ok ? tbl_rdata : '0) :
		sfs_pkg::CELL_W'(cur_q);

	assign step_w = div_step(rem_w_q, num_w_q, grid_cols_q);
	assign step_h = div_step(rem_h_q, num_h_q, grid_rows_q);
	assign step_c = div_step(rem_c_q, num_c_q, grid_cols_q);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			num_w_q <= sfs_pkg::DIV_W'(iw_q);
			num_h_q <= sfs_pkg::DIV_W'(ih_q);
			num_c_q <= sfs_pkg::DIV_W'(cell_idx);
			rem_w_q <= '0;
			rem_h_q <= '0;
			rem_c_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.div_step) begin
			{rem_w_q, num_w_q} <= step_w;
			{rem_h_q, num_h_q} <= step_h;
			{rem_c_q, num_c_q} <= step_c;
			cnt_q              <= cnt_q + 1'b1;
		end
	end

	assign status.div_last = (cnt_q == sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_x_q <= PX_W'(rem_c_q) * PX_W'(num_w_q[sfs_pkg::DIM_W-1:0]);
			prod_y_q <= PY_W'(num_c_q) * PY_W'(num_h_q[sfs_pkg::DIM_W-1:0]);
		end
	end

	assign sat_x = (prod_x_q > PX_W'(DIM_MAX)) ? DIM_MAX : prod_x_q[sfs_pkg::DIM_W-1:0];
	assign sat_y = (prod_y_q > PY_W'(DIM_MAX)) ? DIM_MAX : prod_y_q[sfs_pkg::DIM_W-1:0];
	assign grid_mode = (mode_q == sfs_pkg::MODE_GRID) || (mode_q == sfs_pkg::MODE_SEQ);
	assign grid_ok   = (grid_cols_q != '0) && (grid_rows_q != '0);

	always_comb begin
		res_d.shown_frame = cur_q;
		res_d.flip_h      = flip_h_q;
		res_d.flip_v      = flip_v_q;
		res_d.finished    = fin_q;
		if (grid_mode && grid_ok) begin
			res_d.src_x       = sat_x;
			res_d.src_y       = sat_y;
			res_d.cell_width  = num_w_q[sfs_pkg::DIM_W-1:0];
			res_d.cell_height = num_h_q[sfs_pkg::DIM_W-1:0];
		end else if (grid_mode) begin
			res_d.src_x       = '0;
			res_d.src_y       = '0;
			res_d.cell_width  = '0;
			res_d.cell_height = '0;
		end else begin
			res_d.src_x       = '0;
			res_d.src_y       = '0;
			res_d.cell_width  = iw_q;
			res_d.cell_height = ih_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

### src/sfs_ctrl.sv
// Controller: sequences capture, table read, division, multiply and result hand-off.
module sfs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  sfs_pkg::dp_status_t  status,
	output sfs_pkg::dp_cmd_t     cmd
);

	sfs_pkg::state_t state_q, state_d;
	logic            valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != sfs_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			sfs_pkg::ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = sfs_pkg::ST_READ;
				end
			end
			sfs_pkg::ST_READ:  state_d = sfs_pkg::ST_SETUP;
			sfs_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sfs_pkg::ST_DIV;
			end
			sfs_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = sfs_pkg::ST_MUL;
				end
			end
			sfs_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = sfs_pkg::ST_DONE;
			end
			sfs_pkg::ST_DONE: begin
				if (!valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = sfs_pkg::ST_IDLE;
				end
			end
			default: state_d = sfs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign result_valid = valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && result_stall) |=> valid_q)
		else $error("pending word dropped");

	a_capture_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == sfs_pkg::ST_READ))
		else $error("capture not followed by table read");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfs_pkg::ST_SETUP) |-> ##(sfs_pkg::DIV_W + 1)
		(state_q == sfs_pkg::ST_MUL))
		else $error("divider ran wrong number of steps");

endmodule

### src/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: controller plus datapath.
//
// Use: configuration is written through cfg_we / cfg_index / cfg_data while the
// block is idle; indexes are anim_mode, play_direction, frame_count, grid_cols,
// grid_rows, own_flip_h, own_flip_v, and other indexes are ignored.
// The item channel (item_valid / item_stall / item) takes one word per action:
// tick, draw frame, set frame or write a cell table entry. Every accepted word
// yields exactly one word on the result channel (result_valid / result_stall /
// result): the shown frame, its source rectangle, the mirror flags and the wrap flag.
// Each word passes through capture, table read, divider setup, twelve steps of a
// three-lane restoring divider (one quotient bit per cycle), multiply and result
// load; the next word is taken only after the result load, once the block is idle.
// The result register parts the two sides: the next word is taken while a
// result still waits. If the receiver stalls, the result holds and the block
// stops after finishing the next word until the pending one is taken.
// Reset clears the configuration to its defaults and the current frame to 0.
// The cell table is not cleared; entries must be written before mode 2 reads them.
module sprite_frame_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  sfs_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output sfs_pkg::result_t                result
);

	sfs_pkg::dp_cmd_t    cmd;
	sfs_pkg::dp_status_t status;

	sfs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	sfs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

### sim/tb_sprite_frame_sequencer.sv
`timescale 1ns / 1ps
// Testbench for sprite_frame_sequencer: directed and random words checked against a predictor.
module tb_sprite_frame_sequencer;

	localparam int MODE_ALIAS = 3;
	localparam int DIR_STOP   = 2;
	localparam int DIR_ALIAS  = 3;
	localparam int DIM_MAX    = (1 << sfs_pkg::DIM_W) - 1;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           item_valid;
	logic                           item_stall;
	sfs_pkg::item_t                 item;
	logic                           result_valid;
	logic                           result_stall;
	sfs_pkg::result_t               result;

	logic [1:0]                  p_mode;
	logic [1:0]                  p_dir;
	logic [sfs_pkg::FC_W-1:0]    p_frames;
	logic [sfs_pkg::DVS_W-1:0]   p_cols;
	logic [sfs_pkg::DVS_W-1:0]   p_rows;
	logic                        p_flip_h;
	logic                        p_flip_v;
	logic [sfs_pkg::FRAME_W-1:0] p_frame;
	logic [sfs_pkg::CELL_W-1:0]  p_cells [sfs_pkg::MAX_FRAMES];

	sfs_pkg::result_t expected_rects[$];
	sfs_pkg::result_t want;
	int               errors;
	int               send_idle_pct;
	int               recv_idle_pct;
	int               recv_hold;

	sprite_frame_sequencer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("tb_sprite_frame_sequencer: errors");
		$finish;
	end

	function automatic sfs_pkg::result_t sequence_step(sfs_pkg::item_t w);
		sfs_pkg::result_t r;
		int      fc;
		int      last;
		int      cell_idx;
		int      cols;
		int      rows;
		int      cw;
		int      ch;
		int      px;
		int      py;
		r = '0;
		fc = int'(p_frames);
		case (w.action)
		sfs_pkg::ACT_TICK: begin
			last = (fc == 0) ? 0 : ((fc - 1 > 255) ? 255 : fc - 1);
			if (p_dir == sfs_pkg::DIR_FWD) begin
				if (p_frame >= last) begin
					p_frame = '0;
					r.finished = 1'b1;
				end else
					p_frame = p_frame + 1'b1;
			end else if (p_dir == sfs_pkg::DIR_BWD) begin
				if (p_frame == 0) begin
					p_frame = sfs_pkg::FRAME_W'(last);
					r.finished = 1'b1;
				end else
					p_frame = p_frame - 1'b1;
			end
		end
		sfs_pkg::ACT_DRAW:  p_frame = w.frame_number;
		sfs_pkg::ACT_SET:   p_frame = (w.frame_number < p_frames) ? w.frame_number : '0;
		sfs_pkg::ACT_WRITE: p_cells[w.frame_number] = w.cell_value;
		endcase
		if (p_mode == sfs_pkg::MODE_GRID || p_mode == sfs_pkg::MODE_SEQ) begin
			if (p_cols != 0 && p_rows != 0) begin
				cols = int'(p_cols);
				rows = int'(p_rows);
				cell_idx = (p_mode == sfs_pkg::MODE_GRID) ? int'(p_frame) :
					int'(p_cells[p_frame]);
				cw = int'(w.image_width) / cols;
				ch = int'(w.image_height) / rows;
				px = (cell_idx % cols) * cw;
				py = (cell_idx / cols) * ch;
				r.src_x = sfs_pkg::DIM_W'((px > DIM_MAX) ? DIM_MAX : px);
				r.src_y = sfs_pkg::DIM_W'((py > DIM_MAX) ? DIM_MAX : py);
				r.cell_width = sfs_pkg::DIM_W'(cw);
				r.cell_height = sfs_pkg::DIM_W'(ch);
			end
		end else begin
			r.cell_width = w.image_width;
			r.cell_height = w.image_height;
		end
		r.shown_frame = p_frame;
		r.flip_h = p_flip_h ^ w.actor_mirror_h;
		r.flip_v = p_flip_v ^ w.actor_mirror_v;
		return r;
	endfunction

	function automatic void check_field(string name, int expected, int actual);
		if (expected != actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_rects.size() == 0) begin
				$error("result word with nothing expected: %p", result);
				errors++;
			end else begin
				want = expected_rects.pop_front();
				check_field("shown_frame", int'(want.shown_frame), int'(result.shown_frame));
				check_field("src_x", int'(want.src_x), int'(result.src_x));
				check_field("src_y", int'(want.src_y), int'(result.src_y));
				check_field("cell_width", int'(want.cell_width), int'(result.cell_width));
				check_field("cell_height", int'(want.cell_height), int'(result.cell_height));
				check_field("flip_h", int'(want.flip_h), int'(result.flip_h));
				check_field("flip_v", int'(want.flip_v), int'(result.flip_v));
				check_field("finished", int'(want.finished), int'(result.finished));
			end
		end
	end

	always @(negedge clk) begin
		if (recv_hold > 0) begin
			result_stall <= 1'b1;
			recv_hold--;
		end else
			result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_word(sfs_pkg::item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		expected_rects.push_back(sequence_step(w));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_rects.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(int mode, int dir, int frames, int cols, int rows, int fh, int fv);
		logic [sfs_pkg::CFG_IDX_W-1:0] regs [7];
		int                            vals [7];
		regs = '{sfs_pkg::REG_ANIM_MODE, sfs_pkg::REG_PLAY_DIRECTION, sfs_pkg::REG_FRAME_COUNT,
			sfs_pkg::REG_GRID_COLS, sfs_pkg::REG_GRID_ROWS, sfs_pkg::REG_OWN_FLIP_H,
			sfs_pkg::REG_OWN_FLIP_V};
		vals = '{mode, dir, frames, cols, rows, fh, fv};
		wait_drained();
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i][sfs_pkg::CFG_DATA_W-1:0];
			case (regs[i])
			sfs_pkg::REG_ANIM_MODE:      p_mode = vals[i][1:0];
			sfs_pkg::REG_PLAY_DIRECTION: p_dir = vals[i][1:0];
			sfs_pkg::REG_FRAME_COUNT:    p_frames = vals[i][sfs_pkg::FC_W-1:0];
			sfs_pkg::REG_GRID_COLS:      p_cols = vals[i][sfs_pkg::DVS_W-1:0];
			sfs_pkg::REG_GRID_ROWS:      p_rows = vals[i][sfs_pkg::DVS_W-1:0];
			sfs_pkg::REG_OWN_FLIP_H:     p_flip_h = vals[i][0];
			sfs_pkg::REG_OWN_FLIP_V:     p_flip_v = vals[i][0];
			default: ;
			endcase
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic sfs_pkg::item_t make_word(sfs_pkg::action_t a, int fnum, int cval,
		int iw, int ih, int mh, int mv);
		sfs_pkg::item_t w;
		w.action = a;
		w.frame_number = sfs_pkg::FRAME_W'(fnum);
		w.cell_value = sfs_pkg::CELL_W'(cval);
		w.image_width = sfs_pkg::DIM_W'(iw);
		w.image_height = sfs_pkg::DIM_W'(ih);
		w.actor_mirror_h = 1'(mh);
		w.actor_mirror_v = 1'(mv);
		return w;
	endfunction

	function automatic logic [sfs_pkg::DIM_W-1:0] random_dim();
		case ($urandom_range(7))
		0: return '0;
		1: return '1;
		default: return sfs_pkg::DIM_W'($urandom_range(DIM_MAX));
		endcase
	endfunction

	function automatic sfs_pkg::item_t random_word();
		sfs_pkg::item_t w;
		int    pick;
		pick = $urandom_range(9);
		w.action = (pick < 4) ? sfs_pkg::ACT_TICK : (pick < 6) ? sfs_pkg::ACT_DRAW :
			(pick < 8) ? sfs_pkg::ACT_SET : sfs_pkg::ACT_WRITE;
		if ($urandom_range(1))
			w.frame_number = sfs_pkg::FRAME_W'($urandom_range(p_frames));
		else
			w.frame_number = sfs_pkg::FRAME_W'($urandom_range(255));
		w.cell_value = sfs_pkg::CELL_W'($urandom_range((1 << sfs_pkg::CELL_W) - 1));
		w.image_width = random_dim();
		w.image_height = random_dim();
		w.actor_mirror_h = 1'($urandom_range(1));
		w.actor_mirror_v = 1'($urandom_range(1));
		return w;
	endfunction

	task automatic test_image_mode();
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0));
		send_word(make_word(sfs_pkg::ACT_DRAW, 255, 4095, 4095, 4095, 1, 1));
		send_word(make_word(sfs_pkg::ACT_TICK, 17, 0, 640, 480, 0, 1));
		send_word(make_word(sfs_pkg::ACT_SET, 7, 0, 33, 44, 1, 0));
		configure(int'(sfs_pkg::MODE_IMAGE), int'(sfs_pkg::DIR_BWD), 256, 1, 1, 1, 1);
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 100, 200, 1, 0));
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 100, 200, 0, 0));
		send_word(make_word(sfs_pkg::ACT_SET, 255, 0, 1, 2, 1, 1));
		configure(MODE_ALIAS, DIR_ALIAS, 256, 64, 64, 0, 1);
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 512, 256, 0, 0));
		send_word(make_word(sfs_pkg::ACT_DRAW, 100, 0, 4095, 1, 1, 1));
	endtask

	task automatic test_grid_mode();
		configure(int'(sfs_pkg::MODE_GRID), int'(sfs_pkg::DIR_FWD), 256, 64, 64, 0, 0);
		send_word(make_word(sfs_pkg::ACT_DRAW, 255, 0, 4095, 4095, 0, 0));
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 4095, 4095, 1, 0));
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 4095, 4095, 0, 1));
		configure(int'(sfs_pkg::MODE_GRID), DIR_STOP, 5, 0, 3, 1, 0);
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 300, 300, 0, 0));
		send_word(make_word(sfs_pkg::ACT_SET, 3, 0, 300, 300, 0, 0));
		send_word(make_word(sfs_pkg::ACT_SET, 5, 0, 300, 300, 1, 1));
		configure(int'(sfs_pkg::MODE_GRID), int'(sfs_pkg::DIR_FWD), 3, 3, 0, 0, 1);
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 900, 900, 0, 0));
		configure(int'(sfs_pkg::MODE_GRID), int'(sfs_pkg::DIR_FWD), 1, 1, 1, 1, 1);
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 64, 64, 0, 0));
		send_word(make_word(sfs_pkg::ACT_DRAW, 200, 0, 4095, 100, 1, 0));
	endtask

	task automatic test_cell_table();
		for (int i = 0; i < sfs_pkg::MAX_FRAMES; i++)
			send_word(make_word(sfs_pkg::ACT_WRITE, i, (i == 0) ? 0 :
				(i == sfs_pkg::MAX_FRAMES - 1) ? 4095 :
				$urandom_range((1 << sfs_pkg::CELL_W) - 1), int'(random_dim()),
				int'(random_dim()), $urandom_range(1), $urandom_range(1)));
	endtask

	task automatic test_sequence_mode();
		configure(int'(sfs_pkg::MODE_SEQ), int'(sfs_pkg::DIR_FWD), 4, 2, 2, 1, 0);
		send_word(make_word(sfs_pkg::ACT_WRITE, 3, 4095, 4095, 4095, 0, 0));
		send_word(make_word(sfs_pkg::ACT_DRAW, 3, 0, 4095, 4095, 0, 0));
		send_word(make_word(sfs_pkg::ACT_WRITE, 0, 0, 800, 600, 1, 1));
		send_word(make_word(sfs_pkg::ACT_TICK, 0, 0, 800, 600, 0, 1));
		send_word(make_word(sfs_pkg::ACT_WRITE, 255, 4094, 1000, 1000, 0, 0));
		send_word(make_word(sfs_pkg::ACT_DRAW, 255, 0, 1000, 1000, 1, 0));
	endtask

	task automatic test_random();
		int frames;
		int cols;
		int rows;
		for (int regime = 0; regime < 3; regime++) begin
			send_idle_pct = (regime == 0) ? 10 : (regime == 1) ? 47 : 0;
			recv_idle_pct = (regime == 0) ? 47 : (regime == 1) ? 10 : 0;
			for (int phase = 0; phase < 4; phase++) begin
				case ($urandom_range(4))
				0: frames = 0;
				1: frames = 256;
				2: frames = $urandom_range(1, 8);
				default: frames = $urandom_range(256);
				endcase
				cols = ($urandom_range(7) == 0) ? 0 : ($urandom_range(3) == 0) ? 64 :
					$urandom_range(1, 64);
				rows = ($urandom_range(7) == 0) ? 0 : ($urandom_range(3) == 0) ? 64 :
					$urandom_range(1, 64);
				configure($urandom_range(3), $urandom_range(3), frames, cols, rows,
					$urandom_range(1), $urandom_range(1));
				repeat (42)
					send_word(random_word());
			end
		end
	endtask

	task automatic test_backpressure();
		configure(int'(sfs_pkg::MODE_GRID), int'(sfs_pkg::DIR_FWD), 16, 4, 4, 0, 1);
		recv_hold = 300;
		repeat (12)
			send_word(random_word());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sfs_pkg::REG_ANIM_MODE;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		errors = 0;
		send_idle_pct = 10;
		recv_idle_pct = 47;
		recv_hold = 0;
		p_mode = sfs_pkg::MODE_IMAGE;
		p_dir = sfs_pkg::DIR_FWD;
		p_frames = '0;
		p_cols = sfs_pkg::DVS_W'(1);
		p_rows = sfs_pkg::DVS_W'(1);
		p_flip_h = 1'b0;
		p_flip_v = 1'b0;
		p_frame = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_image_mode();
		test_grid_mode();
		test_cell_table();
		test_sequence_mode();
		test_random();
		test_backpressure();

		item_valid <= 1'b0;
		while (expected_rects.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_sprite_frame_sequencer: clean");
		else
			$display("tb_sprite_frame_sequencer: errors");
		$finish;
	end

endmodule

### files.f
src/sfs_pkg.sv
src/sfs_ram.sv
src/sfs_datapath.sv
src/sfs_ctrl.sv
src/sprite_frame_sequencer.sv
sim/tb_sprite_frame_sequencer.sv
